### rtl/tks_pkg.sv
// Shared types and constants for the top-k source selector.
// Used by tks_entry_ram, tks_ctrl, tks_out_stage and top_k_source_selector.
`default_nettype none

package tks_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEEP_W   = 5;
    localparam int CMP_W    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(10);

    localparam logic [1:0] OP_RANKED = 2'd0;
    localparam logic [1:0] OP_FILL   = 2'd1;
    localparam logic [1:0] OP_OLD    = 2'd2;
    localparam logic [1:0] OP_DRAIN  = 2'd3;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] port;
        logic [15:0] parts;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef struct packed {
        logic   load;
        entry_t data;
        logic   valid;
        logic   last;
    } out_load_t;

    // max_keep clamped to 1..CAPACITY
    function automatic logic [CNT_W-1:0] limit_of(input logic [KEEP_W-1:0] keep);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(keep);
        if (wide == '0) begin
            wide = CMP_W'(1);
        end else if (wide > CMP_W'(CAPACITY)) begin
            wide = CMP_W'(CAPACITY);
        end
        return CNT_W'(wide);
    endfunction

endpackage

`default_nettype wire

### rtl/tks_entry_ram.sv
// Entry store: one write port, one read port, registered read data.
// Depends on tks_pkg for CAPACITY and the entry layout.
`default_nettype none

module tks_entry_ram
    import tks_pkg::*;
(
    input  wire logic     aclk,
    input  wire mem_req_t req,
    output entry_t        rd_data
);

    entry_t mem_array [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_array[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem_array[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/tks_out_stage.sv
// Result register between the sequencer and the m_ channel.
// Depends on tks_pkg for entry_t and out_load_t.
`default_nettype none

module tks_out_stage
    import tks_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire out_load_t  load,
    output logic            free,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [31:0]     m_out_id,
    output logic [15:0]     m_out_port,
    output logic [15:0]     m_out_parts,
    output logic            m_out_valid,
    output logic            m_out_last
);

    logic   m_valid_reg;
    entry_t data_reg;
    logic   ovalid_reg;
    logic   last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load.load) begin
            data_reg   <= load.data;
            ovalid_reg <= load.valid;
            last_reg   <= load.last;
        end
    end

    assign free        = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_out_id    = data_reg.id;
    assign m_out_port  = data_reg.port;
    assign m_out_parts = data_reg.parts;
    assign m_out_valid = ovalid_reg;
    assign m_out_last  = last_reg;

endmodule

`default_nettype wire

### rtl/tks_ctrl.sv
// Sequencer: scans, shifts, appends to and drains the entry store.
// Depends on tks_pkg; drives tks_entry_ram and tks_out_stage.
`default_nettype none

module tks_ctrl
    import tks_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    input  wire logic [KEEP_W-1:0] cfg_max_keep,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [31:0]       s_source_id,
    input  wire logic [15:0]       s_source_port,
    input  wire logic [15:0]       s_part_count,
    input  wire logic              s_is_low_id,
    output mem_req_t               mem_req,
    input  wire entry_t            rd_data,
    input  wire logic              out_free,
    output out_load_t              out_load
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_TAIL     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SHIFT    = 3'd3;
    localparam logic [2:0] S_PLACE    = 3'd4;
    localparam logic [2:0] S_DEDUP    = 3'd5;
    localparam logic [2:0] S_DRAIN_RD = 3'd6;
    localparam logic [2:0] S_DRAIN_WR = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [KEEP_W-1:0] keep_reg;
    entry_t            item_reg, item_next;

    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  cnt_dec;
    logic              in_fire;
    logic              drain_last;

    assign lim        = limit_of(keep_reg);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign cnt_dec    = count_reg - CNT_W'(1);
    assign s_ready    = (state_reg == S_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign drain_last = (idx_inc == count_reg);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        item_next  = item_reg;
        mem_req    = '0;
        out_load   = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    item_next.id    = s_source_id;
                    item_next.port  = s_source_port;
                    item_next.parts = (s_opcode == OP_OLD) ? 16'd0 : s_part_count;
                    idx_next        = '0;
                    if (s_opcode == OP_DRAIN) begin
                        state_next = S_DRAIN_RD;
                    end else if (!s_is_low_id) begin
                        if (s_opcode == OP_RANKED) begin
                            if (count_reg >= lim) begin
                                // full: compare against the tail first
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = cnt_dec[IDX_W-1:0];
                                state_next      = S_TAIL;
                            end else if (count_reg == '0) begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = '0;
                                mem_req.wr_data = item_next;
                                count_next      = CNT_W'(1);
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = '0;
                                state_next      = S_SCAN;
                            end
                        end else if (count_reg < lim) begin
                            if (s_opcode == OP_FILL || count_reg == '0) begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = count_reg[IDX_W-1:0];
                                mem_req.wr_data = item_next;
                                count_next      = count_reg + CNT_W'(1);
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = '0;
                                state_next      = S_DEDUP;
                            end
                        end
                    end
                end
            end

            S_TAIL: begin
                if (item_reg.parts <= rd_data.parts) begin
                    state_next = S_IDLE;
                end else if (cnt_dec == '0) begin
                    // single entry list: overwrite in place
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = '0;
                    mem_req.wr_data = item_reg;
                    state_next      = S_IDLE;
                end else begin
                    count_next      = cnt_dec;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = '0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN: begin
                if (rd_data.parts > item_reg.parts) begin
                    if (idx_inc == count_reg) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = count_reg[IDX_W-1:0];
                        mem_req.wr_data = item_reg;
                        count_next      = count_reg + CNT_W'(1);
                        state_next      = S_IDLE;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_inc[IDX_W-1:0];
                        idx_next        = idx_inc;
                    end
                end else begin
                    // insertion point found; move the tail part up from the end
                    pos_next        = idx_reg;
                    idx_next        = cnt_dec;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = cnt_dec[IDX_W-1:0];
                    state_next      = S_SHIFT;
                end
            end

            S_SHIFT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_inc[IDX_W-1:0];
                mem_req.wr_data = rd_data;
                if (idx_reg == pos_reg) begin
                    state_next = S_PLACE;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_dec[IDX_W-1:0];
                    idx_next        = idx_dec;
                end
            end

            S_PLACE: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg[IDX_W-1:0];
                mem_req.wr_data = item_reg;
                count_next      = count_reg + CNT_W'(1);
                state_next      = S_IDLE;
            end

            S_DEDUP: begin
                if (rd_data.id == item_reg.id && rd_data.port == item_reg.port) begin
                    state_next = S_IDLE;
                end else if (idx_inc == count_reg) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = count_reg[IDX_W-1:0];
                    mem_req.wr_data = item_reg;
                    count_next      = count_reg + CNT_W'(1);
                    state_next      = S_IDLE;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_inc[IDX_W-1:0];
                    idx_next        = idx_inc;
                end
            end

            S_DRAIN_RD: begin
                if (out_free) begin
                    if (count_reg == '0) begin
                        out_load.load  = 1'b1;
                        out_load.data  = '0;
                        out_load.valid = 1'b0;
                        out_load.last  = 1'b1;
                        state_next     = S_IDLE;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_reg[IDX_W-1:0];
                        state_next      = S_DRAIN_WR;
                    end
                end
            end

            S_DRAIN_WR: begin
                // result register was free when the read was issued
                out_load.load  = 1'b1;
                out_load.data  = rd_data;
                out_load.valid = 1'b1;
                out_load.last  = drain_last;
                if (drain_last) begin
                    count_next = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_DRAIN_RD;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            keep_reg  <= KEEP_RESET;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            if (cfg_valid) begin
                keep_reg <= cfg_max_keep;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_shift_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT |-> (idx_reg >= pos_reg && idx_reg < count_reg))
        else $error("shift pointer outside the moved range");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRAIN_WR && drain_last) |=> (count_reg == '0 && state_reg == S_IDLE))
        else $error("list not emptied after final drain transaction");

    a_drain_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load.load |-> out_free)
        else $error("result register loaded while still occupied");

endmodule

`default_nettype wire

### rtl/top_k_source_selector.sv
// Top level of the top-k source selector.
// Depends on tks_pkg, tks_entry_ram, tks_out_stage and tks_ctrl.
//
// Usage:
//   s_ channel: one command per transaction (ranked insert, fill append,
//   old-source append with dedup, drain). s_ready is high only while the
//   sequencer is idle; one command is worked at a time.
//   m_ channel: drain results only, head to tail, m_out_last on the final one.
//   A drain of an empty list gives one result with m_out_valid low.
//   cfg channel: writes max_keep; always ready, write only while idle.
// Command steps; the entry RAM takes one read and one write a cycle:
//   fill append writes at the tail; old-source append reads from the head for
//   a duplicate, then writes at the tail; ranked insert checks the tail first
//   when full, scans from head to the insertion point, then moves the entries
//   behind it up from the tail, one a cycle; drain loads each entry in turn.
// A stalled receiver holds the result register; the drain then waits before
// each RAM read until that register frees. A command is still taken while a
// finished result waits. Reset empties the list and sets max_keep to 10;
// the RAM contents need no clearing since only entries below the count are read.
`default_nettype none

module top_k_source_selector
    import tks_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [KEEP_W-1:0] cfg_max_keep,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [31:0]       s_source_id,
    input  wire logic [15:0]       s_source_port,
    input  wire logic [15:0]       s_part_count,
    input  wire logic              s_is_low_id,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [31:0]            m_out_id,
    output logic [15:0]            m_out_port,
    output logic [15:0]            m_out_parts,
    output logic                   m_out_valid,
    output logic                   m_out_last
);

    mem_req_t  mem_req;
    entry_t    rd_data;
    out_load_t out_load;
    logic      out_free;

    assign cfg_ready = 1'b1;

    tks_entry_ram u_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    tks_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_max_keep  (cfg_max_keep),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_source_id   (s_source_id),
        .s_source_port (s_source_port),
        .s_part_count  (s_part_count),
        .s_is_low_id   (s_is_low_id),
        .mem_req       (mem_req),
        .rd_data       (rd_data),
        .out_free      (out_free),
        .out_load      (out_load)
    );

    tks_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (out_load),
        .free        (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_id    (m_out_id),
        .m_out_port  (m_out_port),
        .m_out_parts (m_out_parts),
        .m_out_valid (m_out_valid),
        .m_out_last  (m_out_last)
    );

endmodule

`default_nettype wire

### tb/tb_top_k_source_selector.sv
// Self-checking testbench for top_k_source_selector: directed table, then random traffic.
// Depends on tks_pkg and the RTL; expected drain output comes from an internal list model.
`timescale 1ns / 1ps

module tb_top_k_source_selector;
    import tks_pkg::*;

    localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
    localparam int DIR_N         = 25;
    localparam int CHUNKS        = 12;
    localparam int CHUNK_ITEMS   = 21;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] id;
        logic [15:0] port;
        logic [15:0] parts;
        logic        low;
    } cmd_t;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] port;
        logic [15:0] parts;
        logic        valid;
        logic        last;
    } drain_beat_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              cfg_en;
        logic [KEEP_W-1:0] cfg_val;
        logic              typed;
        drain_beat_t       beat;
    } dir_row_t;

    localparam drain_beat_t NO_BEAT    = '0;
    localparam drain_beat_t EMPTY_BEAT = '{32'h0, 16'h0, 16'h0, 1'b0, 1'b1};
    localparam drain_beat_t MAX_BEAT   = '{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1};

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [KEEP_W-1:0] cfg_max_keep;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_opcode;
    logic [31:0]       s_source_id;
    logic [15:0]       s_source_port;
    logic [15:0]       s_part_count;
    logic              s_is_low_id;
    logic              m_valid;
    logic              m_ready;
    logic [31:0]       m_out_id;
    logic [15:0]       m_out_port;
    logic [15:0]       m_out_parts;
    logic              m_out_valid;
    logic              m_out_last;

    top_k_source_selector dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_max_keep  (cfg_max_keep),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_source_id   (s_source_id),
        .s_source_port (s_source_port),
        .s_part_count  (s_part_count),
        .s_is_low_id   (s_is_low_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_id      (m_out_id),
        .m_out_port    (m_out_port),
        .m_out_parts   (m_out_parts),
        .m_out_valid   (m_out_valid),
        .m_out_last    (m_out_last)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // list model
    entry_t            held [CAPACITY];
    int                held_n;
    logic [KEEP_W-1:0] keep_reg;
    drain_beat_t       expected_beats [$];
    int                errors;
    int                send_gap;
    int                take_gap;

    function automatic int keep_limit();
        int lim = int'(keep_reg);
        if (lim < 1) begin
            lim = 1;
        end
        if (lim > CAPACITY) begin
            lim = CAPACITY;
        end
        return lim;
    endfunction

    function automatic void rank_source(input cmd_t c);
        int pos;
        if (held_n >= keep_limit()) begin
            // full: only a strictly larger count pushes out the tail
            if (held_n == 0 || c.parts <= held[held_n-1].parts) begin
                return;
            end
            held_n--;
        end
        if (held_n >= CAPACITY) begin
            return;
        end
        pos = 0;
        while (pos < held_n && held[pos].parts > c.parts) begin
            pos++;
        end
        for (int i = held_n; i > pos; i--) begin
            held[i] = held[i-1];
        end
        held[pos] = '{c.id, c.port, c.parts};
        held_n++;
    endfunction

    function automatic void append_source(input cmd_t c, input logic dedup);
        if (held_n >= keep_limit() || held_n >= CAPACITY) begin
            return;
        end
        if (dedup) begin
            for (int i = 0; i < held_n; i++) begin
                if (held[i].id == c.id && held[i].port == c.port) begin
                    return;
                end
            end
        end
        held[held_n] = '{c.id, c.port, dedup ? 16'h0 : c.parts};
        held_n++;
    endfunction

    function automatic void update_list(input cmd_t c, ref drain_beat_t beats [$]);
        if (c.op == OP_DRAIN) begin
            if (held_n == 0) begin
                beats.push_back(EMPTY_BEAT);
            end else begin
                for (int i = 0; i < held_n; i++) begin
                    beats.push_back('{held[i].id, held[i].port, held[i].parts, 1'b1,
                                      (i == held_n - 1)});
                end
            end
            held_n = 0;
        end else if (!c.low) begin
            case (c.op)
                OP_RANKED: begin
                    rank_source(c);
                end
                OP_FILL: begin
                    append_source(c, 1'b0);
                end
                default: begin
                    append_source(c, 1'b1);
                end
            endcase
        end
    endfunction

    task automatic send_cmd(input cmd_t c, input logic typed, input drain_beat_t beat);
        drain_beat_t beats [$];
        while ($urandom_range(0, 99) < send_gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= c.op;
        s_source_id   <= c.id;
        s_source_port <= c.port;
        s_part_count  <= c.parts;
        s_is_low_id   <= c.low;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        update_list(c, beats);
        if (typed) begin
            expected_beats.push_back(beat);
        end else begin
            foreach (beats[i]) begin
                expected_beats.push_back(beats[i]);
            end
        end
    endtask

    // wait out pending drain output plus the longest insert
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] v);
        settle();
        cfg_valid    <= 1'b1;
        cfg_max_keep <= v;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        keep_reg = v;
    endtask

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   roll = $urandom_range(0, 99);
        if (roll < 10) begin
            c.op = OP_DRAIN;
        end else if (roll < 50) begin
            c.op = OP_RANKED;
        end else if (roll < 75) begin
            c.op = OP_FILL;
        end else begin
            c.op = OP_OLD;
        end
        // small id/port pool so duplicates actually occur
        if ($urandom_range(0, 1) == 1) begin
            c.id   = 32'($urandom_range(0, 3));
            c.port = 16'($urandom_range(0, 3));
        end else begin
            c.id   = $urandom;
            c.port = 16'($urandom);
        end
        c.parts = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        c.low   = ($urandom_range(0, 7) == 0);
        return c;
    endfunction

    task automatic flag_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= take_gap);
    end

    always @(posedge aclk) begin
        drain_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h %h %h %b %b",
                         $time, m_out_id, m_out_port, m_out_parts, m_out_valid, m_out_last);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                flag_field("out_id", want.id, m_out_id);
                flag_field("out_port", 32'(want.port), 32'(m_out_port));
                flag_field("out_parts", 32'(want.parts), 32'(m_out_parts));
                flag_field("out_valid", 32'(want.valid), 32'(m_out_valid));
                flag_field("out_last", 32'(want.last), 32'(m_out_last));
            end
        end
    end

    dir_row_t dir_rows [DIR_N] = '{
        '{'{OP_DRAIN,  32'h0,         16'h0,    16'h0,    1'b0}, 1'b0, 5'd0,  1'b1, EMPTY_BEAT},
        '{'{OP_RANKED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_DRAIN,  32'h0,         16'h0,    16'h0,    1'b0}, 1'b0, 5'd0,  1'b1, MAX_BEAT},
        '{'{OP_RANKED, 32'd1,         16'd1,    16'd5,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        // equal count goes ahead of the older entry
        '{'{OP_RANKED, 32'd2,         16'd2,    16'd5,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_RANKED, 32'd3,         16'd3,    16'd0,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_RANKED, 32'd7,         16'd7,    16'd9,    1'b1}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_FILL,   32'd4,         16'd4,    16'd9,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_FILL,   32'd8,         16'd8,    16'd1,    1'b1}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_OLD,    32'd1,         16'd1,    16'd7,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        // old source is kept with zero parts
        '{'{OP_OLD,    32'd1,         16'd2,    16'hFFFF, 1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_OLD,    32'd9,         16'd9,    16'd3,    1'b1}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_DRAIN,  32'h0,         16'h0,    16'h0,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        // max_keep of zero behaves as one
        '{'{OP_FILL,   32'd5,         16'd5,    16'd3,    1'b0}, 1'b1, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_FILL,   32'd6,         16'd6,    16'd8,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_RANKED, 32'd10,        16'd10,   16'd3,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_RANKED, 32'd11,        16'd11,   16'd4,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_OLD,    32'd12,        16'd12,   16'd0,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_DRAIN,  32'h0,         16'h0,    16'h0,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        // out-of-range max_keep saturates to capacity
        '{'{OP_RANKED, 32'hAAAA_5555, 16'h5555, 16'h0,    1'b0}, 1'b1, 5'd31, 1'b0, NO_BEAT},
        '{'{OP_RANKED, 32'h5555_AAAA, 16'hAAAA, 16'hFFFF, 1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_RANKED, 32'd13,        16'd13,   16'd100,  1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        // limit dropped below the count: appends refused, tail still displaced
        '{'{OP_FILL,   32'd14,        16'd14,   16'd1,    1'b0}, 1'b1, 5'd2,  1'b0, NO_BEAT},
        '{'{OP_RANKED, 32'd15,        16'd15,   16'd50,   1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT},
        '{'{OP_DRAIN,  32'h0,         16'h0,    16'h0,    1'b0}, 1'b0, 5'd0,  1'b0, NO_BEAT}
    };

    initial begin
        logic [KEEP_W-1:0] keep_pick;
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_max_keep  <= '0;
        s_valid       <= 1'b0;
        s_opcode      <= OP_RANKED;
        s_source_id   <= '0;
        s_source_port <= '0;
        s_part_count  <= '0;
        s_is_low_id   <= 1'b0;
        m_ready       <= 1'b0;
        errors   = 0;
        held_n   = 0;
        keep_reg = KEEP_RESET;
        send_gap = 7;
        take_gap = 63;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_N; r++) begin
            if (dir_rows[r].cfg_en) begin
                write_keep(dir_rows[r].cfg_val);
            end
            send_cmd(dir_rows[r].cmd, dir_rows[r].typed, dir_rows[r].beat);
        end

        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            case (chunk / 4)
                0: begin
                    send_gap = 7;
                    take_gap = 63;
                end
                1: begin
                    send_gap = 63;
                    take_gap = 7;
                end
                default: begin
                    send_gap = 0;
                    take_gap = 0;
                end
            endcase
            // hit both ends of max_keep early, random settings after that
            case (chunk)
                0: keep_pick = 5'd1;
                1: keep_pick = 5'd16;
                2: keep_pick = 5'd0;
                3: keep_pick = 5'd31;
                default: keep_pick = 5'($urandom_range(0, 31));
            endcase
            write_keep(keep_pick);
            for (int k = 0; k < CHUNK_ITEMS; k++) begin
                send_cmd(rand_cmd(), 1'b0, NO_BEAT);
            end
        end
        send_cmd('{OP_DRAIN, 32'h0, 16'h0, 16'h0, 1'b0}, 1'b0, NO_BEAT);

        settle();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d transactions still expected", $time, expected_beats.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/tks_pkg.sv
rtl/tks_entry_ram.sv
rtl/tks_out_stage.sv
rtl/tks_ctrl.sv
rtl/top_k_source_selector.sv
tb/tb_top_k_source_selector.sv
